FILE: src/rect_fill_engine_defines.svh
// Assertion macros for the rectangle fill engine.
// Included by rect_fill_engine.sv, which carries the concurrent checks; no other dependencies.
`ifndef RECT_FILL_ENGINE_DEFINES_SVH
`define RECT_FILL_ENGINE_DEFINES_SVH

`ifndef SYNTHESIS
`define RFE_ASSERT_IMPLY(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("rect_fill_engine: check failed");
`define RFE_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("rect_fill_engine: check failed");
`else
`define RFE_ASSERT_IMPLY(lbl, clk, rst_n, ante, cons)
`define RFE_ASSERT_NEXT(lbl, clk, rst_n, ante, cons)
`endif

`endif

FILE: src/rfe_pkg.sv
// Shared types and constants for the rectangle fill engine.
// No dependencies; used by rfe_pixel_fmt and rect_fill_engine.
`default_nettype none

package rfe_pkg;

    localparam int RFE_MAX_DIM = 4096;

    // Field widths fixed by the register map
    localparam int ADDR_W  = 32;
    localparam int PITCH_W = 16;
    localparam int POS_W   = 12;
    localparam int SIZE_W  = 13;
    localparam int MODE_W  = 3;
    localparam int DATA_W  = 32;
    localparam int BYTES_W = 3;
    localparam int PADDR_W = 5;

    // Color conversion masks
    localparam logic [15:0] MASK_R565 = 16'hF800;
    localparam logic [15:0] MASK_G565 = 16'h07E0;
    localparam logic [15:0] MASK_B565 = 16'h001F;

    typedef enum logic [2:0] {
        REG_SURFACE_BASE = 3'd0,
        REG_LINE_PITCH   = 3'd1,
        REG_RECT_LEFT    = 3'd2,
        REG_RECT_TOP     = 3'd3,
        REG_RECT_WIDTH   = 3'd4,
        REG_RECT_HEIGHT  = 3'd5,
        REG_FILL_MODE    = 3'd6,
        REG_COLOR_VALUE  = 3'd7
    } t_reg_idx;

    typedef enum logic [2:0] {
        MODE_8BPP          = 3'd0,
        MODE_16BPP         = 3'd1,
        MODE_24BPP         = 3'd2,
        MODE_32BPP         = 3'd3,
        MODE_16BPP_FROM888 = 3'd4,
        MODE_24BPP_FROM565 = 3'd5,
        MODE_32BPP_FROM565 = 3'd6
    } t_fill_mode;

    // Pixel format derived from the mode and color
    typedef struct packed {
        logic [BYTES_W-1:0] bytes;
        logic [DATA_W-1:0]  data;
    } t_pix_fmt;

endpackage

`default_nettype wire

FILE: src/rect_fill_engine.sv
// rect_fill_engine: solid rectangle fill, one pixel write word per accepted tick.
// The result word of an accepted tick is registered on the edge that accepts it.
// Throughput: one word per cycle while the output is not stalled; the walk state and result register update together.
// Longest path is the start address: one 12x16 multiply plus a three-input 32-bit add.
// Reset (synchronous, active low) clears config registers, walk state and output valid.
// Depends on rfe_pkg, rfe_pixel_fmt and rect_fill_engine_defines.svh.
`default_nettype none

`include "rect_fill_engine_defines.svh"

module rect_fill_engine #(
    parameter int MAX_DIM = rfe_pkg::RFE_MAX_DIM
) (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,

    // Config port (APB style)
    input  wire logic                          psel,
    input  wire logic                          penable,
    input  wire logic                          pwrite,
    input  wire logic [rfe_pkg::PADDR_W-1:0]   paddr,
    input  wire logic [31:0]                   pwdata,
    output logic      [31:0]                   prdata,
    output logic                               pready,

    // Tick input channel
    input  wire logic                          i_in_valid,
    output logic                               o_in_stall,
    input  wire logic                          i_start_req,

    // Pixel write output channel
    output logic                               o_out_valid,
    input  wire logic                          i_out_stall,
    output logic                               o_write_valid,
    output logic      [rfe_pkg::ADDR_W-1:0]    o_write_address,
    output logic      [rfe_pkg::DATA_W-1:0]    o_write_data,
    output logic      [rfe_pkg::BYTES_W-1:0]   o_byte_count,
    output logic                               o_last
);

    // Counters only need to hold the saturated dimension
    localparam int DIM_FULL_W = $clog2(MAX_DIM + 1);
    localparam int DIM_W      = (DIM_FULL_W < rfe_pkg::SIZE_W) ? DIM_FULL_W : rfe_pkg::SIZE_W;

    // ------------------------------------------------------------------
    // Config registers
    // ------------------------------------------------------------------
    logic [rfe_pkg::ADDR_W-1:0]  r_surface_base;
    logic [rfe_pkg::PITCH_W-1:0] r_line_pitch;
    logic [rfe_pkg::POS_W-1:0]   r_rect_left;
    logic [rfe_pkg::POS_W-1:0]   r_rect_top;
    logic [rfe_pkg::SIZE_W-1:0]  r_rect_width;
    logic [rfe_pkg::SIZE_W-1:0]  r_rect_height;
    logic [rfe_pkg::MODE_W-1:0]  r_fill_mode;
    logic [rfe_pkg::DATA_W-1:0]  r_color_value;

    logic              cfg_wr;
    rfe_pkg::t_reg_idx cfg_idx;

    assign pready  = 1'b1;
    assign cfg_wr  = psel & penable & pwrite & pready;
    assign cfg_idx = rfe_pkg::t_reg_idx'(paddr[4:2]);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_surface_base <= '0;
            r_line_pitch   <= '0;
            r_rect_left    <= '0;
            r_rect_top     <= '0;
            r_rect_width   <= '0;
            r_rect_height  <= '0;
            r_fill_mode    <= '0;
            r_color_value  <= '0;
        end else if (cfg_wr) begin
            case (cfg_idx)
                rfe_pkg::REG_SURFACE_BASE: r_surface_base <= pwdata;
                rfe_pkg::REG_LINE_PITCH:   r_line_pitch   <= pwdata[15:0];
                rfe_pkg::REG_RECT_LEFT:    r_rect_left    <= pwdata[11:0];
                rfe_pkg::REG_RECT_TOP:     r_rect_top     <= pwdata[11:0];
                rfe_pkg::REG_RECT_WIDTH:   r_rect_width   <= pwdata[12:0];
                rfe_pkg::REG_RECT_HEIGHT:  r_rect_height  <= pwdata[12:0];
                rfe_pkg::REG_FILL_MODE:    r_fill_mode    <= pwdata[2:0];
                rfe_pkg::REG_COLOR_VALUE:  r_color_value  <= pwdata;
                default: ;
            endcase
        end
    end

    always_comb begin
        case (cfg_idx)
            rfe_pkg::REG_SURFACE_BASE: prdata = r_surface_base;
            rfe_pkg::REG_LINE_PITCH:   prdata = {16'd0, r_line_pitch};
            rfe_pkg::REG_RECT_LEFT:    prdata = {20'd0, r_rect_left};
            rfe_pkg::REG_RECT_TOP:     prdata = {20'd0, r_rect_top};
            rfe_pkg::REG_RECT_WIDTH:   prdata = {19'd0, r_rect_width};
            rfe_pkg::REG_RECT_HEIGHT:  prdata = {19'd0, r_rect_height};
            rfe_pkg::REG_FILL_MODE:    prdata = {29'd0, r_fill_mode};
            rfe_pkg::REG_COLOR_VALUE:  prdata = r_color_value;
            default:                   prdata = '0;
        endcase
    end

    // ------------------------------------------------------------------
    // Pixel format: size in bytes and converted color, read live
    // ------------------------------------------------------------------
    rfe_pkg::t_pix_fmt pix_fmt;

    rfe_pixel_fmt u_pixel_fmt (
        .i_mode  (r_fill_mode),
        .i_color (r_color_value),
        .o_fmt   (pix_fmt)
    );

    // ------------------------------------------------------------------
    // Walk state
    // ------------------------------------------------------------------
    logic                       r_busy;
    logic [DIM_W-1:0]           r_row_left;
    logic [DIM_W-1:0]           r_col_left;
    logic [rfe_pkg::ADDR_W-1:0] r_line_address;
    logic [rfe_pkg::ADDR_W-1:0] r_pixel_address;

    logic                       n_busy;
    logic [DIM_W-1:0]           n_row_left;
    logic [DIM_W-1:0]           n_col_left;
    logic [rfe_pkg::ADDR_W-1:0] n_line_address;
    logic [rfe_pkg::ADDR_W-1:0] n_pixel_address;

    // Output register
    logic                        r_out_valid;
    logic                        r_write_valid;
    logic [rfe_pkg::ADDR_W-1:0]  r_write_address;
    logic [rfe_pkg::DATA_W-1:0]  r_write_data;
    logic [rfe_pkg::BYTES_W-1:0] r_byte_count;
    logic                        r_last;

    logic                        n_write_valid;
    logic [rfe_pkg::ADDR_W-1:0]  n_write_address;
    logic [rfe_pkg::DATA_W-1:0]  n_write_data;
    logic [rfe_pkg::BYTES_W-1:0] n_byte_count;
    logic                        n_last;

    logic in_acc;
    logic out_acc;

    // Single result register: a new tick is taken whenever the held word leaves
    assign o_in_stall = r_out_valid & i_out_stall;
    assign in_acc     = i_in_valid & ~o_in_stall;
    assign out_acc    = r_out_valid & ~i_out_stall;

    // Saturated dimensions (values above MAX_DIM clamp)
    logic [DIM_W-1:0] w_sat;
    logic [DIM_W-1:0] h_sat;

    assign w_sat = ({19'd0, r_rect_width} > 32'(MAX_DIM)) ? DIM_W'(MAX_DIM)
                                                           : r_rect_width[DIM_W-1:0];
    assign h_sat = ({19'd0, r_rect_height} > 32'(MAX_DIM)) ? DIM_W'(MAX_DIM)
                                                            : r_rect_height[DIM_W-1:0];

    // Start address: base + top*pitch + left*bytes, wraps at 32 bits
    logic [27:0]                top_ofs;
    logic [14:0]                left_ofs;
    logic [rfe_pkg::ADDR_W-1:0] start_addr;

    assign top_ofs    = 28'(r_rect_top) * 28'(r_line_pitch);
    assign left_ofs   = 15'(r_rect_left) * 15'(pix_fmt.bytes);
    assign start_addr = r_surface_base + 32'(top_ofs) + 32'(left_ofs);

    // State as seen by this tick, after a possible start load
    logic                       cur_busy;
    logic [DIM_W-1:0]           cur_row;
    logic [DIM_W-1:0]           cur_col;
    logic [rfe_pkg::ADDR_W-1:0] cur_line;
    logic [rfe_pkg::ADDR_W-1:0] cur_pix;
    logic                       end_line;
    logic                       is_last;

    always_comb begin
        if (i_start_req) begin
            cur_busy = (w_sat != '0) && (h_sat != '0);
            cur_row  = h_sat;
            cur_col  = w_sat;
            cur_line = start_addr;
            cur_pix  = start_addr;
        end else begin
            cur_busy = r_busy;
            cur_row  = r_row_left;
            cur_col  = r_col_left;
            cur_line = r_line_address;
            cur_pix  = r_pixel_address;
        end

        end_line = (cur_col <= DIM_W'(1));
        // Live width of zero at a line end also finishes the fill
        is_last  = end_line && ((cur_row <= DIM_W'(1)) || (w_sat == '0));

        n_busy          = cur_busy;
        n_row_left      = cur_row;
        n_col_left      = cur_col;
        n_line_address  = cur_line;
        n_pixel_address = cur_pix;

        n_write_valid   = 1'b0;
        n_write_address = '0;
        n_write_data    = '0;
        n_byte_count    = '0;
        n_last          = 1'b0;

        if (cur_busy) begin
            n_write_valid   = 1'b1;
            n_write_address = cur_pix;
            n_write_data    = pix_fmt.data;
            n_byte_count    = pix_fmt.bytes;
            n_last          = is_last;

            if (is_last) begin
                n_busy     = 1'b0;
                n_row_left = '0;
                n_col_left = '0;
            end else if (end_line) begin
                // next line: step line start by pitch, reload column count
                n_row_left      = cur_row - DIM_W'(1);
                n_line_address  = cur_line + 32'(r_line_pitch);
                n_pixel_address = cur_line + 32'(r_line_pitch);
                n_col_left      = w_sat;
            end else begin
                n_col_left      = cur_col - DIM_W'(1);
                n_pixel_address = cur_pix + 32'(pix_fmt.bytes);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy          <= 1'b0;
            r_row_left      <= '0;
            r_col_left      <= '0;
            r_line_address  <= '0;
            r_pixel_address <= '0;
        end else if (in_acc) begin
            r_busy          <= n_busy;
            r_row_left      <= n_row_left;
            r_col_left      <= n_col_left;
            r_line_address  <= n_line_address;
            r_pixel_address <= n_pixel_address;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (in_acc) begin
            r_out_valid <= 1'b1;
        end else if (out_acc) begin
            r_out_valid <= 1'b0;
        end
    end

    // Payload: loaded on accept, held while stalled
    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            r_write_valid   <= n_write_valid;
            r_write_address <= n_write_address;
            r_write_data    <= n_write_data;
            r_byte_count    <= n_byte_count;
            r_last          <= n_last;
        end
    end

    assign o_out_valid     = r_out_valid;
    assign o_write_valid   = r_write_valid;
    assign o_write_address = r_write_address;
    assign o_write_data    = r_write_data;
    assign o_byte_count    = r_byte_count;
    assign o_last          = r_last;

    // ------------------------------------------------------------------
    // Checks
    // ------------------------------------------------------------------
    // every accepted tick yields a result word on the next cycle
    `RFE_ASSERT_NEXT(a_acc_gives_word, i_clk, i_rst_n, in_acc, r_out_valid)
    // the last write of a fill leaves the engine idle
    `RFE_ASSERT_NEXT(a_last_ends_fill, i_clk, i_rst_n, in_acc && n_last, !r_busy)
    // a running fill always has pixels left to issue
    `RFE_ASSERT_IMPLY(a_busy_counts, i_clk, i_rst_n, r_busy, (r_col_left != '0) && (r_row_left != '0))
    // a flagged last word is always a real write
    `RFE_ASSERT_IMPLY(a_last_is_write, i_clk, i_rst_n, r_out_valid && r_last, r_write_valid)

endmodule

`default_nettype wire

FILE: src/rfe_pixel_fmt.sv
// Pixel size and color conversion for the fill engine.
// Depends on rfe_pkg.
`default_nettype none

module rfe_pixel_fmt (
    input  wire logic [rfe_pkg::MODE_W-1:0] i_mode,
    input  wire logic [rfe_pkg::DATA_W-1:0] i_color,
    output rfe_pkg::t_pix_fmt               o_fmt
);

    logic [15:0] c565;
    logic [31:0] c888;

    // 888 -> 565: R[23:19], G[15:10], B[7:3]
    assign c565 = ((i_color[23:8] & rfe_pkg::MASK_R565)) |
                  ((i_color[20:5] & rfe_pkg::MASK_G565)) |
                  ((i_color[18:3] & rfe_pkg::MASK_B565));

    // 565 -> 888, low bits zero
    assign c888 = {8'd0, i_color[15:11], 3'd0, i_color[10:5], 2'd0, i_color[4:0], 3'd0};

    always_comb begin
        case (rfe_pkg::t_fill_mode'(i_mode))
            rfe_pkg::MODE_8BPP: begin
                o_fmt.bytes = 3'd1;
                o_fmt.data  = {24'd0, i_color[7:0]};
            end
            rfe_pkg::MODE_16BPP: begin
                o_fmt.bytes = 3'd2;
                o_fmt.data  = {16'd0, i_color[15:0]};
            end
            rfe_pkg::MODE_24BPP: begin
                o_fmt.bytes = 3'd3;
                o_fmt.data  = {8'd0, i_color[23:0]};
            end
            rfe_pkg::MODE_16BPP_FROM888: begin
                o_fmt.bytes = 3'd2;
                o_fmt.data  = {16'd0, c565};
            end
            rfe_pkg::MODE_24BPP_FROM565: begin
                o_fmt.bytes = 3'd3;
                o_fmt.data  = c888;
            end
            rfe_pkg::MODE_32BPP_FROM565: begin
                o_fmt.bytes = 3'd4;
                o_fmt.data  = c888;
            end
            default: begin
                // 32bpp native, also the unused mode code
                o_fmt.bytes = 3'd4;
                o_fmt.data  = i_color;
            end
        endcase
    end

endmodule

`default_nettype wire

FILE: sim/rect_fill_engine_tb.sv
// Self-checking bench for rect_fill_engine: APB register setup, tick words in,
// pixel write words checked field by field against a cycle-free fill walk model.
// Depends on rfe_pkg and the rect_fill_engine RTL.

module rect_fill_engine_tb;
    timeunit 1ns;
    timeprecision 1ps;

    // One pixel write word as it leaves the engine
    typedef struct packed {
        logic                        wr_valid;
        logic [rfe_pkg::ADDR_W-1:0]  addr;
        logic [rfe_pkg::DATA_W-1:0]  data;
        logic [rfe_pkg::BYTES_W-1:0] nbytes;
        logic                        last;
    } t_pix_write;

    localparam logic [2:0] MODE_UNUSED    = 3'd7;  // no package name; acts as 32bpp
    localparam int         IDLE_LIMIT     = 1000;  // cycles with no word moving
    localparam int         REPORT_MAX     = 10;
    localparam int         RANDOM_TICKS   = 1000;
    localparam int         FILL_CAP       = 300;   // ticks per random fill, at most, before the idle extras
    localparam int         OVERSIZE_TICKS = 150;   // ticks into each oversize fill

    // Shadow of the register file plus the rectangle walk; each accepted tick
    // yields exactly one expected write word (valid or idle).
    class fill_write_board;
        logic [31:0] base = '0, pitch = '0, left = '0, top = '0;
        logic [31:0] width = '0, height = '0, color = '0;
        logic [2:0]  mode = '0;
        bit          busy = 1'b0;
        logic [31:0] rows_left = '0, cols_left = '0, line_addr = '0, pix_addr = '0;
        t_pix_write  due_writes[$];
        int          mismatches = 0, writes_seen = 0, fills_done = 0, idle_words = 0;

        function void set_reg(rfe_pkg::t_reg_idx idx, logic [31:0] v);
            case (idx)
                rfe_pkg::REG_SURFACE_BASE: base   = v;
                rfe_pkg::REG_LINE_PITCH:   pitch  = {16'b0, v[15:0]};
                rfe_pkg::REG_RECT_LEFT:    left   = {20'b0, v[11:0]};
                rfe_pkg::REG_RECT_TOP:     top    = {20'b0, v[11:0]};
                rfe_pkg::REG_RECT_WIDTH:   width  = {19'b0, v[12:0]};
                rfe_pkg::REG_RECT_HEIGHT:  height = {19'b0, v[12:0]};
                rfe_pkg::REG_FILL_MODE:    mode   = v[2:0];
                rfe_pkg::REG_COLOR_VALUE:  color  = v;
                default: ;
            endcase
        endfunction

        function logic [31:0] clip_dim(logic [31:0] v);
            return (v > rfe_pkg::RFE_MAX_DIM) ? rfe_pkg::RFE_MAX_DIM : v;
        endfunction

        function logic [31:0] pixel_bytes();
            case (mode)
                rfe_pkg::MODE_8BPP:                               return 1;
                rfe_pkg::MODE_16BPP, rfe_pkg::MODE_16BPP_FROM888: return 2;
                rfe_pkg::MODE_24BPP, rfe_pkg::MODE_24BPP_FROM565: return 3;
                default:                                          return 4;
            endcase
        endfunction

        function logic [31:0] fill_color();
            case (mode)
                rfe_pkg::MODE_8BPP:          return {24'b0, color[7:0]};
                rfe_pkg::MODE_16BPP:         return {16'b0, color[15:0]};
                rfe_pkg::MODE_24BPP:         return {8'b0, color[23:0]};
                rfe_pkg::MODE_16BPP_FROM888:
                    return {16'b0, color[23:19], color[15:10], color[7:3]};
                rfe_pkg::MODE_24BPP_FROM565, rfe_pkg::MODE_32BPP_FROM565:
                    return {8'b0, color[15:11], 3'b0, color[10:5], 2'b0, color[4:0], 3'b0};
                default:                     return color;
            endcase
        endfunction

        // Advance the walk by one accepted tick and queue the write it causes
        function void take_tick(bit start);
            logic [31:0] nb, w, h;
            bit          end_line, is_last;
            t_pix_write  wr;
            nb = pixel_bytes();
            w  = clip_dim(width);
            if (start) begin
                h         = clip_dim(height);
                busy      = (w != 0) && (h != 0);
                rows_left = h;
                cols_left = w;
                line_addr = base + top * pitch + left * nb;   // wraps at 32 bits
                pix_addr  = line_addr;
            end
            wr = '0;
            if (busy) begin
                end_line = (cols_left <= 1);
                // a width cleared mid-fill ends the fill at the end of the line
                is_last  = end_line && (rows_left <= 1 || w == 0);
                wr = '{1'b1, pix_addr, fill_color(), nb[rfe_pkg::BYTES_W-1:0], is_last};
                if (is_last) begin
                    busy      = 1'b0;
                    rows_left = 0;
                    cols_left = 0;
                end else if (end_line) begin
                    rows_left = rows_left - 1;
                    line_addr = line_addr + pitch;
                    pix_addr  = line_addr;
                    cols_left = w;
                end else begin
                    cols_left = cols_left - 1;
                    pix_addr  = pix_addr + nb;
                end
            end
            due_writes.push_back(wr);
        endfunction

        function void note_fail(string msg);
            mismatches++;
            if (mismatches <= REPORT_MAX)
                $display("[%0t] MISMATCH %s", $time, msg);
        endfunction

        function void compare_write(t_pix_write got);
            t_pix_write want;
            if (due_writes.size() == 0) begin
                note_fail($sformatf("unexpected word v=%0d a=%h d=%h n=%0d l=%0d",
                    got.wr_valid, got.addr, got.data, got.nbytes, got.last));
                return;
            end
            want = due_writes.pop_front();
            if (want.wr_valid) writes_seen++;
            else idle_words++;
            if (want.last) fills_done++;
            if (got.wr_valid !== want.wr_valid || got.addr !== want.addr ||
                got.data !== want.data || got.nbytes !== want.nbytes ||
                got.last !== want.last)
                note_fail($sformatf(
                    "exp v=%0d a=%h d=%h n=%0d l=%0d / got v=%0d a=%h d=%h n=%0d l=%0d",
                    want.wr_valid, want.addr, want.data, want.nbytes, want.last,
                    got.wr_valid, got.addr, got.data, got.nbytes, got.last));
        endfunction
    endclass

    // ---------------------------------------------------------------
    // DUT hookup; every input starts at a known value
    // ---------------------------------------------------------------
    logic                          i_clk = 1'b0;
    logic                          i_rst_n = 1'b0;
    logic                          psel = 1'b0, penable = 1'b0, pwrite = 1'b0;
    logic [rfe_pkg::PADDR_W-1:0]   paddr = '0;
    logic [31:0]                   pwdata = '0;
    logic [31:0]                   prdata;
    logic                          pready;
    logic                          i_in_valid = 1'b0;
    logic                          o_in_stall;
    logic                          i_start_req = 1'b0;
    logic                          o_out_valid;
    logic                          i_out_stall = 1'b0;
    logic                          o_write_valid;
    logic [rfe_pkg::ADDR_W-1:0]    o_write_address;
    logic [rfe_pkg::DATA_W-1:0]    o_write_data;
    logic [rfe_pkg::BYTES_W-1:0]   o_byte_count;
    logic                          o_last;

    rect_fill_engine u_top (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .psel            (psel),
        .penable         (penable),
        .pwrite          (pwrite),
        .paddr           (paddr),
        .pwdata          (pwdata),
        .prdata          (prdata),
        .pready          (pready),
        .i_in_valid      (i_in_valid),
        .o_in_stall      (o_in_stall),
        .i_start_req     (i_start_req),
        .o_out_valid     (o_out_valid),
        .i_out_stall     (i_out_stall),
        .o_write_valid   (o_write_valid),
        .o_write_address (o_write_address),
        .o_write_data    (o_write_data),
        .o_byte_count    (o_byte_count),
        .o_last          (o_last)
    );

    fill_write_board board;
    int              burst_left = 0;   // ticks left in the current sender burst
    int              ticks_sent = 0;

    initial begin
        forever #10 i_clk = ~i_clk;
    end

    // ---------------------------------------------------------------
    // Receiver: stall style is redrawn at random intervals (none, light
    // random, heavy random, periodic); runs are capped so words keep moving
    // ---------------------------------------------------------------
    int stall_style = 0, stall_window = 0, stall_run = 0, stall_tick = 0;

    always @(posedge i_clk) begin : rx_stall
        logic want;
        if (stall_window == 0) begin
            stall_style  = $urandom_range(0, 3);
            stall_window = $urandom_range(16, 80);
        end else begin
            stall_window = stall_window - 1;
        end
        stall_tick = stall_tick + 1;
        case (stall_style)
            0:       want = 1'b0;
            1:       want = ($urandom_range(0, 3) == 0);
            2:       want = ($urandom_range(0, 3) != 0);
            default: want = ((stall_tick % 5) < 2);
        endcase
        want      = want && (stall_run < 8);
        stall_run = want ? stall_run + 1 : 0;
        i_out_stall <= want;
    end

    // Output monitor: values read right after the edge are the pre-edge ones
    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && !i_out_stall)
            board.compare_write({o_write_valid, o_write_address, o_write_data,
                                 o_byte_count, o_last});
    end

    // Watchdog: ends the run when no word moves for too long
    initial begin : watchdog
        int quiet = 0;
        while (quiet < IDLE_LIMIT) begin
            @(posedge i_clk);
            if (!i_rst_n || (i_in_valid && !o_in_stall) || (o_out_valid && !i_out_stall))
                quiet = 0;
            else
                quiet++;
        end
        $display("Timeout: no word moved for %0d cycles", IDLE_LIMIT);
        $display("Test completed with failures");
        $finish;
    end

    // ---------------------------------------------------------------
    // Drivers
    // ---------------------------------------------------------------

    // One tick word; the sender works in bursts with random gaps in between.
    // Valid stays up between back-to-back words and the payload holds while stalled.
    task automatic send_tick(input bit start);
        int gap;
        if (burst_left == 0) begin
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
            if (gap > 0) begin
                i_in_valid <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
            burst_left = $urandom_range(1, 40);
        end
        burst_left--;
        i_in_valid  <= 1'b1;
        i_start_req <= start;
        do @(posedge i_clk); while (o_in_stall);
        board.take_tick(start);
        ticks_sent++;
    endtask

    // Hold off the sender until every expected write word is back.
    // Checked at the falling edge so the monitor's pop has settled.
    task automatic drain_writes();
        i_in_valid <= 1'b0;
        burst_left = 0;
        while (board.due_writes.size() != 0) @(negedge i_clk);
        @(posedge i_clk);
    endtask

    // APB write: setup cycle, then access cycle until pready
    task automatic write_reg(input rfe_pkg::t_reg_idx idx, input logic [31:0] value);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= value;
        @(posedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        board.set_reg(idx, value);
    endtask

    // Zero, all ones or random within the field
    function automatic logic [31:0] pick_bits(input logic [31:0] mask);
        case ($urandom_range(0, 7))
            0:       return '0;
            1:       return mask;
            default: return $urandom & mask;
        endcase
    endfunction

    // Rectangle sizes stay small so fills run to completion often
    function automatic logic [31:0] pick_dim();
        case ($urandom_range(0, 19))
            0:       return 0;
            1:       return $urandom_range(9, 24);
            default: return $urandom_range(1, 6);
        endcase
    endfunction

    // One random phase: reprogram some registers while idle, then either a
    // well-formed fill (start plus continuation ticks, rare restarts, maybe
    // a width change halfway) or a short run of random start bits.
    task automatic random_fill_phase();
        int          n, i, cut;
        logic [31:0] w, h;
        drain_writes();
        if ($urandom_range(0, 1)) write_reg(rfe_pkg::REG_SURFACE_BASE, pick_bits(32'hFFFF_FFFF));
        if ($urandom_range(0, 1)) write_reg(rfe_pkg::REG_LINE_PITCH, pick_bits(32'h0000_FFFF));
        if ($urandom_range(0, 1)) write_reg(rfe_pkg::REG_RECT_LEFT, pick_bits(32'h0000_0FFF));
        if ($urandom_range(0, 1)) write_reg(rfe_pkg::REG_RECT_TOP, pick_bits(32'h0000_0FFF));
        if ($urandom_range(0, 1)) write_reg(rfe_pkg::REG_RECT_WIDTH, pick_dim());
        if ($urandom_range(0, 1)) write_reg(rfe_pkg::REG_RECT_HEIGHT, pick_dim());
        if ($urandom_range(0, 1)) write_reg(rfe_pkg::REG_FILL_MODE, $urandom_range(0, 7));
        if ($urandom_range(0, 1)) write_reg(rfe_pkg::REG_COLOR_VALUE, pick_bits(32'hFFFF_FFFF));

        if ($urandom_range(0, 9) == 0) begin
            repeat ($urandom_range(4, 12)) send_tick($urandom_range(0, 1));
            return;
        end

        w = board.clip_dim(board.width);
        h = board.clip_dim(board.height);
        n = (w == 0 || h == 0) ? 2 : w * h;
        if (n > FILL_CAP) n = FILL_CAP;
        n   = n + $urandom_range(0, 3);        // a few idle ticks past the end
        cut = ($urandom_range(0, 7) == 0) ? n / 2 : -1;
        send_tick(1'b1);
        for (i = 1; i < n; i++) begin
            if (i == cut) begin
                // live register change mid-fill, width often cleared
                drain_writes();
                write_reg(rfe_pkg::REG_RECT_WIDTH, $urandom_range(0, 1) ? 32'd0 : pick_dim());
            end
            send_tick($urandom_range(0, 29) == 0);
            if ($urandom_range(0, 199) == 0) drain_writes();
        end
    endtask

    // ---------------------------------------------------------------
    // Main sequence
    // ---------------------------------------------------------------
    initial begin : main_seq
        int random_from;
        board = new();
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Idle tick from reset, then a start with the empty reset rectangle
        send_tick(1'b0);
        send_tick(1'b1);
        drain_writes();

        // 2x2 in the far corner at max pitch; start address wraps past 2^32
        write_reg(rfe_pkg::REG_SURFACE_BASE, 32'hFFFF_FFF0);
        write_reg(rfe_pkg::REG_LINE_PITCH, 32'h0000_FFFF);
        write_reg(rfe_pkg::REG_RECT_LEFT, 32'd4095);
        write_reg(rfe_pkg::REG_RECT_TOP, 32'd4095);
        write_reg(rfe_pkg::REG_RECT_WIDTH, 32'd2);
        write_reg(rfe_pkg::REG_RECT_HEIGHT, 32'd2);
        write_reg(rfe_pkg::REG_FILL_MODE, rfe_pkg::MODE_32BPP);
        write_reg(rfe_pkg::REG_COLOR_VALUE, 32'hFFFF_FFFF);
        send_tick(1'b1);
        repeat (4) send_tick(1'b0);
        drain_writes();

        // Unused mode code behaves as 32bpp; 1x1 ends on its first write
        write_reg(rfe_pkg::REG_SURFACE_BASE, 32'd0);
        write_reg(rfe_pkg::REG_LINE_PITCH, 32'd0);
        write_reg(rfe_pkg::REG_RECT_LEFT, 32'd0);
        write_reg(rfe_pkg::REG_RECT_TOP, 32'd0);
        write_reg(rfe_pkg::REG_RECT_WIDTH, 32'd1);
        write_reg(rfe_pkg::REG_RECT_HEIGHT, 32'd1);
        write_reg(rfe_pkg::REG_FILL_MODE, MODE_UNUSED);
        write_reg(rfe_pkg::REG_COLOR_VALUE, 32'd0);
        send_tick(1'b1);
        drain_writes();

        // 888 -> 565, with a restart while the fill is running
        write_reg(rfe_pkg::REG_RECT_WIDTH, 32'd3);
        write_reg(rfe_pkg::REG_FILL_MODE, rfe_pkg::MODE_16BPP_FROM888);
        write_reg(rfe_pkg::REG_COLOR_VALUE, $urandom);
        send_tick(1'b1);
        send_tick(1'b0);
        send_tick(1'b1);
        send_tick(1'b0);
        send_tick(1'b0);
        drain_writes();

        // Width cleared mid-fill: the pixel closing the line is the last one
        write_reg(rfe_pkg::REG_RECT_HEIGHT, 32'd3);
        write_reg(rfe_pkg::REG_FILL_MODE, rfe_pkg::MODE_24BPP_FROM565);
        write_reg(rfe_pkg::REG_COLOR_VALUE, 32'h0000_FFFF);
        send_tick(1'b1);
        send_tick(1'b0);
        drain_writes();
        write_reg(rfe_pkg::REG_RECT_WIDTH, 32'd0);
        send_tick(1'b0);
        send_tick(1'b0);
        drain_writes();

        // Zero height with nonzero width: start produces only an idle word
        write_reg(rfe_pkg::REG_RECT_WIDTH, 32'd2);
        write_reg(rfe_pkg::REG_RECT_HEIGHT, 32'd0);
        send_tick(1'b1);
        drain_writes();

        // Remaining modes, one pixel each
        write_reg(rfe_pkg::REG_RECT_HEIGHT, 32'd1);
        write_reg(rfe_pkg::REG_RECT_WIDTH, 32'd1);
        write_reg(rfe_pkg::REG_COLOR_VALUE, $urandom);
        write_reg(rfe_pkg::REG_FILL_MODE, rfe_pkg::MODE_32BPP_FROM565);
        send_tick(1'b1);
        drain_writes();
        write_reg(rfe_pkg::REG_FILL_MODE, rfe_pkg::MODE_16BPP);
        send_tick(1'b1);
        drain_writes();
        write_reg(rfe_pkg::REG_FILL_MODE, rfe_pkg::MODE_24BPP);
        send_tick(1'b1);
        drain_writes();
        write_reg(rfe_pkg::REG_FILL_MODE, rfe_pkg::MODE_8BPP);
        send_tick(1'b1);

        // Random phases
        random_from = ticks_sent;
        while (ticks_sent - random_from < RANDOM_TICKS)
            random_fill_phase();

        // Oversize width saturates: walk into a long line, no early end
        drain_writes();
        write_reg(rfe_pkg::REG_RECT_WIDTH, 32'h1FFF);
        write_reg(rfe_pkg::REG_RECT_HEIGHT, 32'd1);
        write_reg(rfe_pkg::REG_FILL_MODE, $urandom_range(0, 7));
        send_tick(1'b1);
        repeat (OVERSIZE_TICKS) send_tick(1'b0);

        // Oversize height saturates: one-pixel lines, closed by clearing the width
        drain_writes();
        write_reg(rfe_pkg::REG_RECT_WIDTH, 32'd1);
        write_reg(rfe_pkg::REG_RECT_HEIGHT, $urandom_range(rfe_pkg::RFE_MAX_DIM + 1, 8191));
        send_tick(1'b1);
        repeat (OVERSIZE_TICKS) send_tick(1'b0);
        drain_writes();
        write_reg(rfe_pkg::REG_RECT_WIDTH, 32'd0);
        repeat (2) send_tick(1'b0);

        // Wait out the tail; extra cycles catch any stray words
        drain_writes();
        repeat (4) @(posedge i_clk);

        $display("Ran %0d ticks: %0d pixel writes, %0d idle words, %0d fills ended with last.",
                 ticks_sent, board.writes_seen, board.idle_words, board.fills_done);
        $display("Mismatching words: %0d, words still owed: %0d.",
                 board.mismatches, board.due_writes.size());
        if (board.mismatches == 0 && board.due_writes.size() == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end

endmodule
